// ===== rtl/wsfp_pkg.sv =====
package wsfp_pkg;

   localparam int LenW = 63;
   localparam int KeyW = 32;

   typedef enum logic [2:0] {
      PH_FIRST = 3'd0,
      PH_LEN7  = 3'd1,
      PH_LEN16 = 3'd2,
      PH_LEN64 = 3'd3,
      PH_KEY   = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      FEND_NONE  = 2'd0,
      FEND_MORE  = 2'd1,
      FEND_FINAL = 2'd2
   } frame_end_type;

   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [2:0] LAST_LEN16_BYTE = 3'd1;
   localparam logic [2:0] LAST_LEN64_BYTE = 3'd7;
   localparam logic [2:0] LAST_KEY_BYTE   = 3'd3;

endpackage

// ===== rtl/websocket_frame_parser.sv =====
// WebSocket frame parser: takes one stream byte per transaction on the req_ channel and returns
// exactly one result per byte on the rsp_ channel, registered in the cycle after acceptance. Header bytes
// come back raw with the header fields decoded so far; payload bytes come back with
// rsp_is_payload set and, for text and binary frames with the mask bit set, unmasked with the
// 4-byte key. The byte that completes a frame carries rsp_frame_end (1: FIN clear, 2: FIN set);
// an empty frame ends on its last header byte. The top bit of a 64-bit extended length is
// dropped. Throughput is one byte per cycle while req_stall is low; the path that sets the
// clock is the 63-bit payload index increment and its compare with the frame length. The output
// register is refilled in the same cycle it is drained, so req_stall only rises while a result
// is held by rsp_stall.
module websocket_frame_parser
   import wsfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_in_byte,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_payload,
   output logic [1:0]      rsp_frame_end,
   output logic            rsp_fin_flag,
   output logic [2:0]      rsp_rsv_bits,
   output logic [3:0]      rsp_frame_opcode,
   output logic            rsp_masked_flag,
   output logic [LenW-1:0] rsp_payload_length
);

   phase_type       phase_ff, phase_in;
   logic            fin_ff, fin_in;
   logic [2:0]      rsv_ff, rsv_in;
   logic [3:0]      opcode_ff, opcode_in;
   logic            mask_ff, mask_in;
   logic [LenW-1:0] length_ff, length_in;
   logic [2:0]      count_ff, count_in;
   logic [KeyW-1:0] key_ff, key_in;
   logic [LenW-1:0] index_ff, index_in;

   logic [LenW-1:0] index_inc;
   logic [7:0]      key_byte;
   logic [6:0]      len7;
   logic            header_end;
   logic            data_end;
   frame_end_type   fend_in;
   logic [7:0]      obyte_in;
   logic            is_pay_in;

   logic            rsp_valid_ff;
   logic [7:0]      rsp_byte_ff;
   logic            rsp_pay_ff;
   frame_end_type   rsp_fend_ff;
   logic            rsp_fin_ff;
   logic [2:0]      rsp_rsv_ff;
   logic [3:0]      rsp_opcode_ff;
   logic            rsp_mask_ff;
   logic [LenW-1:0] rsp_length_ff;

   logic            req_accept;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign len7      = req_in_byte[6:0];
   assign index_inc = index_ff + LenW'(1);
   assign data_end  = (index_inc >= length_ff);

   always_comb begin
      case (index_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Datapath: next header fields, length, key and index.
   always_comb begin
      fin_in     = fin_ff;
      rsv_in     = rsv_ff;
      opcode_in  = opcode_ff;
      mask_in    = mask_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      index_in   = index_ff;
      obyte_in   = req_in_byte;
      is_pay_in  = 1'b0;
      header_end = 1'b0;
      case (phase_ff)
         PH_LEN7: begin
            mask_in  = req_in_byte[7];
            count_in = 3'd0;
            if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
               length_in = '0;
            end else begin
               length_in  = LenW'(len7);
               header_end = !req_in_byte[7];
            end
         end
         PH_LEN16: begin
            length_in = LenW'({length_ff[7:0], req_in_byte});
            if (count_ff >= LAST_LEN16_BYTE) begin
               count_in   = 3'd0;
               header_end = !mask_ff;
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         PH_LEN64: begin
            length_in = {length_ff[LenW-9:0], req_in_byte};
            if (count_ff >= LAST_LEN64_BYTE) begin
               count_in   = 3'd0;
               header_end = !mask_ff;
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         PH_KEY: begin
            key_in = {key_ff[KeyW-9:0], req_in_byte};
            if (count_ff >= LAST_KEY_BYTE) begin
               count_in   = 3'd0;
               header_end = 1'b1;
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         PH_DATA: begin
            is_pay_in = 1'b1;
            if (mask_ff && (opcode_ff == OP_TEXT || opcode_ff == OP_BINARY)) begin
               obyte_in = req_in_byte ^ key_byte;
            end
            index_in = index_inc;
         end
         default: begin
            fin_in    = req_in_byte[7];
            rsv_in    = req_in_byte[6:4];
            opcode_in = req_in_byte[3:0];
            mask_in   = 1'b0;
            length_in = '0;
            index_in  = '0;
            count_in  = 3'd0;
         end
      endcase
      if (header_end) begin
         index_in = '0;
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_LEN7: begin
            if (len7 == LEN7_EXT16) begin
               phase_in = PH_LEN16;
            end else if (len7 == LEN7_EXT64) begin
               phase_in = PH_LEN64;
            end else if (req_in_byte[7]) begin
               phase_in = PH_KEY;
            end
         end
         PH_LEN16: begin
            if (count_ff >= LAST_LEN16_BYTE && mask_ff) begin
               phase_in = PH_KEY;
            end
         end
         PH_LEN64: begin
            if (count_ff >= LAST_LEN64_BYTE && mask_ff) begin
               phase_in = PH_KEY;
            end
         end
         PH_KEY:  phase_in = phase_ff;
         PH_DATA: begin
            if (data_end) begin
               phase_in = PH_FIRST;
            end
         end
         default: phase_in = PH_LEN7;
      endcase
      if (header_end) begin
         phase_in = (length_in == '0) ? PH_FIRST : PH_DATA;
      end
   end

   // Frame end code.
   always_comb begin
      if ((header_end && length_in == '0) || (phase_ff == PH_DATA && data_end)) begin
         fend_in = fin_ff ? FEND_FINAL : FEND_MORE;
      end else begin
         fend_in = FEND_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         fin_ff    <= 1'b0;
         rsv_ff    <= 3'd0;
         opcode_ff <= 4'd0;
         mask_ff   <= 1'b0;
         length_ff <= '0;
         count_ff  <= 3'd0;
         key_ff    <= '0;
         index_ff  <= '0;
      end else if (req_accept) begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         rsv_ff    <= rsv_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         key_ff    <= key_in;
         index_ff  <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_byte_ff   <= obyte_in;
         rsp_pay_ff    <= is_pay_in;
         rsp_fend_ff   <= fend_in;
         rsp_fin_ff    <= fin_in;
         rsp_rsv_ff    <= rsv_in;
         rsp_opcode_ff <= opcode_in;
         rsp_mask_ff   <= mask_in;
         rsp_length_ff <= length_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = rsp_byte_ff;
   assign rsp_is_payload     = rsp_pay_ff;
   assign rsp_frame_end      = rsp_fend_ff;
   assign rsp_fin_flag       = rsp_fin_ff;
   assign rsp_rsv_bits       = rsp_rsv_ff;
   assign rsp_frame_opcode   = rsp_opcode_ff;
   assign rsp_masked_flag    = rsp_mask_ff;
   assign rsp_payload_length = rsp_length_ff;

   // A payload byte always produces a payload result.
   a_data_is_payload: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_DATA |=> rsp_valid && rsp_is_payload)
      else $error("payload byte did not yield a payload result");

   // A completed frame returns the parser to the first header byte.
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      req_accept && fend_in != FEND_NONE |=> phase_ff == PH_FIRST)
      else $error("frame end did not restart the header walk");

   // The payload phase is never entered with an empty frame.
   a_data_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> length_ff != '0)
      else $error("payload phase with zero length");

   // A final frame end reports the FIN bit.
   a_final_has_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end == FEND_FINAL |-> rsp_fin_flag)
      else $error("final frame end without FIN");

   // A result waiting on rsp_stall blocks the next transaction.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while result held");

endmodule
